// ===== rtl/dtrm_pkg.sv =====
`default_nettype none

package dtrm_pkg;

  localparam int MAP_WIDE_DEF   = 22;
  localparam int MAP_HIGH_DEF   = 15;
  localparam int TILE_SHIFT_DEF = 4;

  localparam int COORD_W     = 16;
  localparam int ROW_SEL_W   = 6;
  localparam int ROW_BITS_W  = 22;
  localparam int CMD_KIND_W  = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  localparam logic MODE_MARK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [CMD_KIND_W-1:0] {
    CMD_REJECT,
    CMD_ACCEPT,
    CMD_MARK,
    CMD_READ
  } cmd_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  function automatic int row_idx_w(input int h);
    return (h > 1) ? $clog2(h) : 1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dtrm_front.sv =====
`default_nettype none

module dtrm_front #(
  parameter int MAP_WIDE   = dtrm_pkg::MAP_WIDE_DEF,
  parameter int MAP_HIGH   = dtrm_pkg::MAP_HIGH_DEF,
  parameter int TILE_SHIFT = dtrm_pkg::TILE_SHIFT_DEF,
  localparam int ROW_W     = dtrm_pkg::row_idx_w(MAP_HIGH),
  localparam int CMD_W     = dtrm_pkg::CMD_KIND_W + MAP_WIDE + 2 * ROW_W
) (
  input  logic                                 mode,
  input  logic signed [dtrm_pkg::COORD_W-1:0]  left_px,
  input  logic signed [dtrm_pkg::COORD_W-1:0]  top_px,
  input  logic signed [dtrm_pkg::COORD_W-1:0]  right_px,
  input  logic signed [dtrm_pkg::COORD_W-1:0]  bottom_px,
  input  logic        [dtrm_pkg::ROW_SEL_W-1:0] row_select,
  output logic        [CMD_W-1:0]              cmd
);
  import dtrm_pkg::*;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [MAP_WIDE-1:0] span;
    logic [ROW_W-1:0]    ys;
    logic [ROW_W-1:0]    ye;
  } cmd_t;

  localparam logic signed [COORD_W-1:0] X_LAST  = COORD_W'(MAP_WIDE - 1);
  localparam logic signed [COORD_W-1:0] X_CLAMP = COORD_W'(MAP_WIDE - 2);
  localparam logic signed [COORD_W-1:0] Y_HIGH  = COORD_W'(MAP_HIGH);
  localparam logic signed [COORD_W-1:0] Y_CLAMP = COORD_W'(MAP_HIGH - 1);

  logic signed [COORD_W-1:0] xs, ys, xe, ye;
  logic signed [COORD_W-1:0] xs_c, ys_c, xe_c, ye_c;
  logic                      reject, empty, row_in;
  logic [MAP_WIDE-1:0]       span;
  cmd_t                      c;

  assign xs = left_px >>> TILE_SHIFT;
  assign ys = top_px >>> TILE_SHIFT;
  assign xe = right_px >>> TILE_SHIFT;
  assign ye = bottom_px >>> TILE_SHIFT;

  assign xs_c = xs[COORD_W-1] ? '0 : xs;
  assign ys_c = ys[COORD_W-1] ? '0 : ys;
  assign xe_c = (xe >= X_LAST) ? X_CLAMP : xe;
  assign ye_c = (ye >= Y_HIGH) ? Y_CLAMP : ye;

  assign reject = (!xs[COORD_W-1] && xs >= X_LAST) || (!ys[COORD_W-1] && ys > Y_HIGH) ||
                  xe[COORD_W-1] || ye[COORD_W-1];
  assign empty  = (xs_c > xe_c) || (ys_c > ye_c);
  assign row_in = {1'b0, row_select} < (ROW_SEL_W + 1)'(MAP_HIGH);

  always_comb begin
    for (int i = 0; i < MAP_WIDE; i++) begin
      span[i] = (xs_c <= COORD_W'(i)) && (COORD_W'(i) <= xe_c);
    end
  end

  always_comb begin
    c.span = span;
    if (mode == MODE_READ) begin
      c.kind = row_in ? CMD_READ : CMD_ACCEPT;
      c.ys   = ROW_W'(row_select);
      c.ye   = ROW_W'(row_select);
    end else begin
      if (reject) begin
        c.kind = CMD_REJECT;
      end else if (empty) begin
        c.kind = CMD_ACCEPT;
      end else begin
        c.kind = CMD_MARK;
      end
      c.ys = ROW_W'(ys_c);
      c.ye = ROW_W'(ye_c);
    end
  end

  assign cmd = c;

endmodule

`default_nettype wire

// ===== rtl/dtrm_queue.sv =====
`default_nettype none

module dtrm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);
  import dtrm_pkg::*;

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             do_push, do_pop;

  assign push_ready = !rst && (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dtrm_back.sv =====
`default_nettype none

module dtrm_back #(
  parameter int MAP_WIDE = dtrm_pkg::MAP_WIDE_DEF,
  parameter int MAP_HIGH = dtrm_pkg::MAP_HIGH_DEF,
  localparam int ROW_W   = dtrm_pkg::row_idx_w(MAP_HIGH),
  localparam int CMD_W   = dtrm_pkg::CMD_KIND_W + MAP_WIDE + 2 * ROW_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  logic [CMD_W-1:0]                   q_cmd,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dtrm_pkg::OUT_TDATA_W-1:0]   out_data
);
  import dtrm_pkg::*;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [MAP_WIDE-1:0] span;
    logic [ROW_W-1:0]    ys;
    logic [ROW_W-1:0]    ye;
  } cmd_t;

  cmd_t                qc, cur;
  state_t              state, state_next;
  logic [ROW_W-1:0]    y, y_next, rd_addr;
  logic [MAP_WIDE-1:0] mem [MAP_HIGH];
  logic [MAP_HIGH-1:0] row_valid;
  logic [MAP_WIDE-1:0] rd_q, row_cur;
  logic                rd_v;
  logic                out_free, take, load, load_acc, wr_en, clr;
  logic [ROW_BITS_W-1:0]          load_bits, row_low;
  logic [MAP_WIDE+ROW_BITS_W-1:0] row_ext;

  assign qc       = q_cmd;
  assign out_free = !out_valid || out_ready;
  assign row_cur  = rd_v ? rd_q : '0;
  assign row_ext  = {{ROW_BITS_W{1'b0}}, row_cur};
  assign row_low  = row_ext[ROW_BITS_W-1:0];

  always_comb begin
    state_next = state;
    y_next     = y;
    q_pop      = 1'b0;
    take       = 1'b0;
    load       = 1'b0;
    load_acc   = 1'b0;
    load_bits  = '0;
    wr_en      = 1'b0;
    clr        = 1'b0;
    rd_addr    = y;
    case (state)
      ST_IDLE: begin
        rd_addr = qc.ys;
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (qc.kind)
            CMD_REJECT: load = 1'b1;
            CMD_ACCEPT: begin
              load     = 1'b1;
              load_acc = 1'b1;
            end
            default: begin
              take       = 1'b1;
              y_next     = qc.ys;
              state_next = ST_UPDATE;
            end
          endcase
        end
      end
      ST_UPDATE: begin
        rd_addr = (y == cur.ye) ? y : y + 1'b1;
        if (cur.kind == CMD_READ) begin
          clr        = 1'b1;
          load       = 1'b1;
          load_acc   = 1'b1;
          load_bits  = row_low;
          state_next = ST_IDLE;
        end else begin
          wr_en = 1'b1;
          if (y == cur.ye) begin
            load       = 1'b1;
            load_acc   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            y_next = y + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    y <= y_next;
    if (take) begin
      cur <= qc;
    end
  end

  // row memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[y] <= row_cur | cur.span;
    end
    rd_q <= mem[rd_addr];
  end

  // rows never written since reset or clear read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_v      <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[y] <= 1'b1;
      end else if (clr) begin
        row_valid[y] <= 1'b0;
      end
      rd_v <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {1'b0, load_bits, load_acc};
    end
  end

  a_row_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> (y <= cur.ye))
    else $error("row walk passed end row");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result loaded over a pending one");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && cur.kind != CMD_READ && y != cur.ye) |=>
      (state == ST_UPDATE && y == $past(y) + 1'b1))
    else $error("mark walk did not advance one row");

  a_busy_kind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> (cur.kind == CMD_MARK || cur.kind == CMD_READ))
    else $error("busy on a request without row work");

endmodule

`default_nettype wire

// ===== rtl/dirty_tile_rectangle_marker_top.sv =====
`default_nettype none

// Dirty tile map: MAP_HIGH rows of MAP_WIDE bits, cleared at reset by per-row valid flags
// (no clearing pass). A request with tuser = 0 marks a pixel rectangle; the corners are
// floored to tiles by TILE_SHIFT, clipped (last column reserved) and the covered bits set;
// the result reports accepted or rejected. A request with tuser = 1 returns the selected
// row in row_bits and clears it. Every request yields exactly one result, in order. The
// front classifies a request in the cycle it is taken and queues it (two entries); the back
// then finishes a rejected or empty rectangle, or a read of a row past the map, in its idle
// state, a row read in the update state, which reads and clears the row, and a mark with
// one read-modify-write of the row memory per row covered; it takes a request only while
// its result register is free or being taken. s_tready is low during reset.
module dirty_tile_rectangle_marker_top #(
  parameter int MAP_WIDE   = dtrm_pkg::MAP_WIDE_DEF,
  parameter int MAP_HIGH   = dtrm_pkg::MAP_HIGH_DEF,
  parameter int TILE_SHIFT = dtrm_pkg::TILE_SHIFT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // left_px[15:0], top_px[31:16], right_px[47:32], bottom_px[63:48], row_select[69:64]
  input  logic [dtrm_pkg::IN_TDATA_W-1:0]     s_tdata,
  // mode
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // accepted[0], row_bits[22:1]
  output logic [dtrm_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import dtrm_pkg::*;

  localparam int ROW_W = row_idx_w(MAP_HIGH);
  localparam int CMD_W = CMD_KIND_W + MAP_WIDE + 2 * ROW_W;

  logic [CMD_W-1:0] front_cmd, q_cmd;
  logic             q_valid, q_pop;

  dtrm_front #(
    .MAP_WIDE   (MAP_WIDE),
    .MAP_HIGH   (MAP_HIGH),
    .TILE_SHIFT (TILE_SHIFT)
  ) u_front (
    .mode       (s_tuser),
    .left_px    (s_tdata[15:0]),
    .top_px     (s_tdata[31:16]),
    .right_px   (s_tdata[47:32]),
    .bottom_px  (s_tdata[63:48]),
    .row_select (s_tdata[69:64]),
    .cmd        (front_cmd)
  );

  dtrm_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_data  (front_cmd),
    .push_ready (s_tready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_cmd)
  );

  dtrm_back #(
    .MAP_WIDE (MAP_WIDE),
    .MAP_HIGH (MAP_HIGH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
